@@ design/bufu_pkg.sv @@
// Shared types and constants for the buffered serial front end.
`default_nettype none
package bufu_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_LINE_RX  = 3'd0;
  localparam logic [2:0] OP_HOST_WR  = 3'd1;
  localparam logic [2:0] OP_HOST_RD  = 3'd2;
  localparam logic [2:0] OP_RX_FLUSH = 3'd3;
  localparam logic [2:0] OP_TX_READY = 3'd4;

  // configuration register indexes
  localparam logic CFG_RX_ENABLE = 1'b0;
  localparam logic CFG_TX_ENABLE = 1'b1;

  localparam logic [7:0] NO_BYTE = 8'hFF;
  localparam int unsigned COUNT_W = 7;

  // command to one FIFO for the current item
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } fifo_cmd_t;

endpackage
`default_nettype wire

@@ design/bufu_if.sv @@
// Channel interfaces: input items and result items.
`default_nettype none
interface bufu_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] data_byte;
  logic       frame_error;
  logic       parity_error;
  logic       overrun_error;
  logic       holding_empty;
  logic       shift_done;

  modport source (output valid, operation, data_byte, frame_error, parity_error,
                  overrun_error, holding_empty, shift_done, input ready);
  modport sink (input valid, operation, data_byte, frame_error, parity_error,
                overrun_error, holding_empty, shift_done, output ready);
endinterface

interface bufu_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       line_valid;
  logic [7:0] line_byte;
  logic [6:0] receive_count;
  logic [6:0] transmit_count;
  logic       transmit_complete;
  logic       write_dropped;
  logic       receive_dropped;

  modport source (output valid, read_byte, read_valid, line_valid, line_byte,
                  receive_count, transmit_count, transmit_complete, write_dropped,
                  receive_dropped, input ready);
  modport sink (input valid, read_byte, read_valid, line_valid, line_byte,
                receive_count, transmit_count, transmit_complete, write_dropped,
                receive_dropped, output ready);
endinterface
`default_nettype wire

@@ design/bufu_ram.sv @@
// Generic single-clock RAM, one write port, one registered read port.
`default_nettype none
module bufu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/bufu_fifo.sv @@
// Circular FIFO: head and fill counters around one RAM.
`default_nettype none
module bufu_fifo #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bufu_pkg::fifo_cmd_t         cmd,
  input  wire logic [7:0]                  wdata,
  output logic      [$clog2(DEPTH+1)-1:0]  fill,
  output logic      [$clog2(DEPTH+1)-1:0]  fill_next,
  output logic      [7:0]                  rdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;

  // fill < DEPTH on a push, so the sum stays below twice the depth
  assign tail_sum = {1'b0, head} + (AW+1)'(fill);
  assign tail = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                             : AW'(tail_sum);

  always_comb begin
    head_next = head;
    fill_next = fill;
    if (cmd.flush) begin
      head_next = '0;
      fill_next = '0;
    end else if (cmd.push) begin
      fill_next = fill + CW'(1);
    end else if (cmd.pop) begin
      head_next = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      fill_next = fill - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  bufu_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail),
    .wdata (wdata),
    .re    (cmd.pop),
    .raddr (head),
    .rdata (rdata)
  );

endmodule
`default_nettype wire

@@ design/buffered_uart_fifo_front_core.sv @@
// Top level of the buffered serial front end: decode, FIFOs, result register.
//
//  channel  dir  handshake      payload
//  item     in   valid/ready    operation, data_byte, error flags, holding_empty, shift_done
//  result   out  valid/ready    read/line bytes, counts, complete and drop flags
//  cfg      in   cfg_we         cfg_index selects receive_enable / transmit_enable
//
// An item is decoded in the cycle it is accepted: FIFO counters and RAM writes
// commit at that edge, and a pop starts its RAM read there. The read data is held in the
// RAM output register until the pending stage moves into the result register.
// One item per cycle is sustained while the result side keeps up.
// Reset (rst, synchronous) empties both FIFOs and sets both enables; RAM contents
// are left as they are. A stalled result holds the pending stage, which holds ready low.
`default_nettype none
module buffered_uart_fifo_front_core #(
  parameter int unsigned RECEIVE_DEPTH  = 64,
  parameter int unsigned TRANSMIT_DEPTH = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  bufu_item_if.sink   item,
  bufu_result_if.source result,
  input  wire logic   cfg_we,
  input  wire logic   cfg_index,
  input  wire logic   cfg_data
);

  localparam int unsigned RX_CW = $clog2(RECEIVE_DEPTH + 1);
  localparam int unsigned TX_CW = $clog2(TRANSMIT_DEPTH + 1);

  // configuration
  logic rx_enable;
  logic tx_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable <= 1'b1;
      tx_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        bufu_pkg::CFG_RX_ENABLE: rx_enable <= cfg_data;
        bufu_pkg::CFG_TX_ENABLE: tx_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  // FIFO state
  bufu_pkg::fifo_cmd_t rx_cmd;
  bufu_pkg::fifo_cmd_t tx_cmd;
  logic [RX_CW-1:0] rx_fill;
  logic [RX_CW-1:0] rx_fill_next;
  logic [TX_CW-1:0] tx_fill;
  logic [TX_CW-1:0] tx_fill_next;
  logic [7:0] rx_rdata;
  logic [7:0] tx_rdata;

  // handshake
  logic accept;
  logic load_out;
  logic p_valid;
  logic o_valid;

  assign load_out   = p_valid && (!o_valid || result.ready);
  assign item.ready = !rst && (!p_valid || load_out);
  assign accept     = item.valid && item.ready;

  // decode of the accepted item
  logic       rx_empty;
  logic       rx_full;
  logic       tx_empty;
  logic       tx_full;
  logic       any_error;
  logic       d_line_valid;
  logic [7:0] d_line_byte;
  logic       d_write_dropped;
  logic       d_receive_dropped;

  assign rx_empty  = (rx_fill == '0);
  assign rx_full   = (rx_fill >= RX_CW'(RECEIVE_DEPTH));
  assign tx_empty  = (tx_fill == '0);
  assign tx_full   = (tx_fill >= TX_CW'(TRANSMIT_DEPTH));
  assign any_error = item.frame_error | item.parity_error | item.overrun_error;

  always_comb begin
    rx_cmd            = '0;
    tx_cmd            = '0;
    d_line_valid      = 1'b0;
    d_line_byte       = 8'h00;
    d_write_dropped   = 1'b0;
    d_receive_dropped = 1'b0;
    if (accept) begin
      case (item.operation)
        bufu_pkg::OP_LINE_RX: begin
          if (!rx_enable || any_error || rx_full) begin
            d_receive_dropped = 1'b1;
          end else begin
            rx_cmd.push = 1'b1;
          end
        end
        bufu_pkg::OP_HOST_WR: begin
          if (tx_enable) begin
            if (tx_empty && item.holding_empty) begin
              // straight to the transmitter, bypassing the queue
              d_line_valid = 1'b1;
              d_line_byte  = item.data_byte;
            end else if (!tx_full) begin
              tx_cmd.push = 1'b1;
            end else begin
              d_write_dropped = 1'b1;
            end
          end
        end
        bufu_pkg::OP_HOST_RD: begin
          rx_cmd.pop = rx_enable && !rx_empty;
        end
        bufu_pkg::OP_RX_FLUSH: begin
          rx_cmd.flush = rx_enable;
        end
        bufu_pkg::OP_TX_READY: begin
          tx_cmd.pop   = tx_enable && !tx_empty;
          d_line_valid = tx_enable && !tx_empty;
        end
        default: ;
      endcase
    end
  end

  bufu_fifo #(.DEPTH (RECEIVE_DEPTH)) u_rx_fifo (
    .clk       (clk),
    .rst       (rst),
    .cmd       (rx_cmd),
    .wdata     (item.data_byte),
    .fill      (rx_fill),
    .fill_next (rx_fill_next),
    .rdata     (rx_rdata)
  );

  bufu_fifo #(.DEPTH (TRANSMIT_DEPTH)) u_tx_fifo (
    .clk       (clk),
    .rst       (rst),
    .cmd       (tx_cmd),
    .wdata     (item.data_byte),
    .fill      (tx_fill),
    .fill_next (tx_fill_next),
    .rdata     (tx_rdata)
  );

  // pending stage: holds the accepted item until the RAM read data is available
  logic       p_rx_pop;
  logic       p_tx_pop;
  logic       p_line_valid;
  logic [7:0] p_line_byte;
  logic [6:0] p_rx_count;
  logic [6:0] p_tx_count;
  logic       p_complete;
  logic       p_write_dropped;
  logic       p_receive_dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (load_out) begin
      p_valid <= 1'b0;
    end
    if (accept) begin
      p_rx_pop          <= rx_cmd.pop;
      p_tx_pop          <= tx_cmd.pop;
      p_line_valid      <= d_line_valid;
      p_line_byte       <= d_line_byte;
      // counts wrap modulo 128 for deep FIFOs
      p_rx_count        <= rx_enable ? bufu_pkg::COUNT_W'(rx_fill_next) : '0;
      p_tx_count        <= tx_enable ? bufu_pkg::COUNT_W'(tx_fill_next) : '0;
      p_complete        <= !tx_enable || (tx_fill_next == '0 && item.shift_done);
      p_write_dropped   <= d_write_dropped;
      p_receive_dropped <= d_receive_dropped;
    end
  end

  // result register
  logic [7:0] o_read_byte;
  logic       o_read_valid;
  logic       o_line_valid;
  logic [7:0] o_line_byte;
  logic [6:0] o_rx_count;
  logic [6:0] o_tx_count;
  logic       o_complete;
  logic       o_write_dropped;
  logic       o_receive_dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_out) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
    if (load_out) begin
      o_read_byte       <= p_rx_pop ? rx_rdata : bufu_pkg::NO_BYTE;
      o_read_valid      <= p_rx_pop;
      o_line_valid      <= p_line_valid;
      o_line_byte       <= p_tx_pop ? tx_rdata : p_line_byte;
      o_rx_count        <= p_rx_count;
      o_tx_count        <= p_tx_count;
      o_complete        <= p_complete;
      o_write_dropped   <= p_write_dropped;
      o_receive_dropped <= p_receive_dropped;
    end
  end

  assign result.valid             = o_valid;
  assign result.read_byte         = o_read_byte;
  assign result.read_valid        = o_read_valid;
  assign result.line_valid        = o_line_valid;
  assign result.line_byte         = o_line_byte;
  assign result.receive_count     = o_rx_count;
  assign result.transmit_count    = o_tx_count;
  assign result.transmit_complete = o_complete;
  assign result.write_dropped     = o_write_dropped;
  assign result.receive_dropped   = o_receive_dropped;

`ifndef NO_ASSERTIONS
  a_accept_fills_pending: assert property (@(posedge clk) disable iff (rst)
    accept |=> p_valid)
    else $error("accepted transfer did not reach the pending stage");

  a_rx_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rx_fill <= RX_CW'(RECEIVE_DEPTH))
    else $error("receive fill above depth");

  a_tx_push_room: assert property (@(posedge clk) disable iff (rst)
    tx_cmd.push |-> tx_fill < TX_CW'(TRANSMIT_DEPTH))
    else $error("transmit push into a full FIFO");

  a_read_exclusive: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_read_valid |-> !o_line_valid && !o_write_dropped && !o_receive_dropped)
    else $error("host read result carries transmit or drop flags");
`endif

endmodule
`default_nettype wire
